/* hdl/swtm_pkg.sv */
// Package for the sliding-window trimmed-mean unit.
// Window geometry, derived widths, cell word and control types, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package swtm_pkg;

  localparam int WINDOW_LEN = 30;
  localparam int DROP_HIGH  = 2;
  localparam int KEEP_COUNT = 25;

  localparam int SAMPLE_W   = 16;
  localparam int LAST_RANK  = (DROP_HIGH + KEEP_COUNT > WINDOW_LEN) ?
                              WINDOW_LEN : DROP_HIGH + KEEP_COUNT;
  localparam int DIVISOR    = (KEEP_COUNT == 0) ? 1 : KEEP_COUNT;

  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int AGE_W      = $clog2(WINDOW_LEN);
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);

  // floor(2^SUM_W / DIVISOR); estimate is low by at most one
  localparam int RECIP_W    = SUM_W + 1;
  localparam longint unsigned RECIP = (64'd1 << SUM_W) / DIVISOR;
  localparam int PROD_W     = SUM_W + RECIP_W;

  typedef struct packed {
    logic                vld;
    logic [SAMPLE_W-1:0] val;
    logic [AGE_W-1:0]    age;
  } swtm_entry_t;

  typedef struct packed {
    logic                del_en;
    logic                ins_en;
    logic [SAMPLE_W-1:0] ins_value;
  } swtm_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } swtm_state_t;

endpackage

/* hdl/sliding_window_trimmed_mean_unit.sv */
// Sliding-window trimmed-mean unit: top level with cell row, summing sequencer
// and output register. Depends on swtm_pkg, swtm_cell, swtm_divider.
//
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one 16-bit word per item.
//   Output channel out_valid/out_ready/out_filtered returns one word per item:
//   floor of the mean of ranks DROP_HIGH .. DROP_HIGH+KEEP_COUNT-1 of the
//   WINDOW_LEN most recent samples, ranked largest first.
//   The window is kept sorted in a row of WINDOW_LEN cells. The accept cycle
//   drops the oldest word, the next cycle inserts the new one, then the
//   sequencer walks the row one rank per cycle summing the kept ranks, then
//   the reciprocal divide is loaded in ST_MUL and taken in ST_OUT.
//   A new word is not taken until the last one has been summed and divided.
//   in_ready is high only while the sequencer is idle. A result waiting on
//   out_ready does not block the next accept; the sequencer holds in its last
//   state until the output register is free.
//   Reset (rst_n low, synchronous) clears the window to zeros, which rank in
//   with the first samples, and drops any pending result.
`timescale 1ns / 1ps

module sliding_window_trimmed_mean_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swtm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swtm_pkg::SAMPLE_W-1:0] out_filtered
);

  import swtm_pkg::*;

  swtm_state_t state_r, state_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r;

  swtm_ctl_t   ctl;
  swtm_entry_t cell_q  [WINDOW_LEN];
  logic        cell_gt [WINDOW_LEN];
  logic        cell_del[WINDOW_LEN];
  logic [SAMPLE_W-1:0] quot;
  logic        in_acc;
  logic        out_load;
  logic        div_load;
  logic        kept;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign ctl.del_en    = in_acc;
  assign ctl.ins_en    = (state_r == ST_INS);
  assign ctl.ins_value = sample_r;

  genvar g;
  generate
    for (g = 0; g < WINDOW_LEN; g++) begin : g_cell
      swtm_entry_t up_w;
      swtm_entry_t dn_w;
      logic        up_gt_w;
      logic        del_w;

      if (g == 0) begin : g_head
        assign up_w    = '0;
        assign up_gt_w = 1'b0;
        assign del_w   = 1'b0;
      end else begin : g_mid
        assign up_w    = cell_q[g-1];
        assign up_gt_w = cell_gt[g-1];
        assign del_w   = cell_del[g-1];
      end

      if (g == WINDOW_LEN - 1) begin : g_tail
        assign dn_w = '0;
      end else begin : g_body
        assign dn_w = cell_q[g+1];
      end

      swtm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .rst_age_i (AGE_W'(g)),
        .ctl_i     (ctl),
        .up_i      (up_w),
        .up_gt_i   (up_gt_w),
        .dn_i      (dn_w),
        .del_i     (del_w),
        .q_o       (cell_q[g]),
        .gt_o      (cell_gt[g]),
        .del_o     (cell_del[g])
      );
    end
  endgenerate

  assign div_load = (state_r == ST_MUL);

  swtm_divider u_div (
    .clk    (clk),
    .load_i (div_load),
    .sum_i  (acc_r),
    .quot_o (quot)
  );

  assign kept = (int'(idx_r) >= DROP_HIGH) && (int'(idx_r) < LAST_RANK);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        idx_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (kept) begin
          acc_nxt = acc_r + SUM_W'(cell_q[idx_r].val);
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(WINDOW_LEN - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_acc) begin
      sample_r <= in_sample;
    end
    if (out_load) begin
      out_data_r <= quot;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  // row status for checks
  logic [WINDOW_LEN-1:0] age_zero_vec;
  logic [WINDOW_LEN-1:0] vld_vec;
  logic                  sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      age_zero_vec[i] = cell_q[i].vld && (cell_q[i].age == '0);
      vld_vec[i]      = cell_q[i].vld;
    end
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      if (cell_q[i].val < cell_q[i+1].val) begin
        sorted_ok = 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_ins: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_INS)
    else $error("accepted word did not start insert");

  a_one_newest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> $countones(age_zero_vec) == 1)
    else $error("window does not hold exactly one newest word");

  a_row_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> &vld_vec)
    else $error("empty cell in window during sum");

  a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> sorted_ok)
    else $error("window row not in descending order");
`endif

endmodule

/* hdl/swtm_cell.sv */
// One rank of the sorted window: holds a value, its age and a valid flag.
// Delete shifts up from the cell below; insert shifts down from the cell above.
// Depends on swtm_pkg.
`timescale 1ns / 1ps

module swtm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [swtm_pkg::AGE_W-1:0] rst_age_i,
  input  swtm_pkg::swtm_ctl_t       ctl_i,
  input  swtm_pkg::swtm_entry_t     up_i,
  input  logic                      up_gt_i,
  input  swtm_pkg::swtm_entry_t     dn_i,
  input  logic                      del_i,
  output swtm_pkg::swtm_entry_t     q_o,
  output logic                      gt_o,
  output logic                      del_o
);

  import swtm_pkg::*;

  swtm_entry_t ent_r, ent_nxt;

  assign q_o   = ent_r;
  // new word ranks above this cell (empty cells rank lowest)
  assign gt_o  = !ent_r.vld || (ctl_i.ins_value > ent_r.val);
  // oldest word sits here or above
  assign del_o = del_i || (ent_r.vld && (ent_r.age == AGE_W'(WINDOW_LEN - 1)));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl_i.del_en && del_o) begin
      ent_nxt = dn_i;
    end else if (ctl_i.ins_en) begin
      if (gt_o) begin
        if (up_gt_i) begin
          ent_nxt     = up_i;
          ent_nxt.age = up_i.age + 1'b1;
        end else begin
          ent_nxt.vld = 1'b1;
          ent_nxt.val = ctl_i.ins_value;
          ent_nxt.age = '0;
        end
      end else begin
        ent_nxt.age = ent_r.age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b1;
      ent_r.val <= '0;
      ent_r.age <= rst_age_i;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

/* hdl/swtm_divider.sv */
// Constant divide of the trimmed sum by the keep count.
// Reciprocal multiply registered, then one compare-and-subtract correction.
// Depends on swtm_pkg.
`timescale 1ns / 1ps

module swtm_divider (
  input  logic                          clk,
  input  logic                          load_i,
  input  logic [swtm_pkg::SUM_W-1:0]    sum_i,
  output logic [swtm_pkg::SAMPLE_W-1:0] quot_o
);

  import swtm_pkg::*;

  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  q_est;
  logic [SUM_W-1:0]  back;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  q_fix;

  always_ff @(posedge clk) begin
    if (load_i) begin
      sum_r  <= sum_i;
      prod_r <= PROD_W'(sum_i) * PROD_W'(RECIP_W'(RECIP));
    end
  end

  always_comb begin
    // product scaled by 2^SUM_W
    q_est = prod_r[SUM_W +: SUM_W];
    back  = SUM_W'(q_est * SUM_W'(DIVISOR));
    rem   = sum_r - back;
    q_fix = (rem >= SUM_W'(DIVISOR)) ? q_est + 1'b1 : q_est;
  end

  assign quot_o = q_fix[SAMPLE_W-1:0];

endmodule

/* tb/trimmed_mean_checker.sv */
// Checker for the sliding-window trimmed-mean unit: watches both channels,
// predicts each filtered word from its own window copy and compares in order.
// Depends on swtm_pkg for the window geometry.
`timescale 1ns / 1ps

module trimmed_mean_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [swtm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swtm_pkg::SAMPLE_W-1:0] out_filtered,
  output int unsigned                   mismatches,
  output int unsigned                   pending,
  output int unsigned                   words_checked
);

  localparam int WIN  = swtm_pkg::WINDOW_LEN;
  localparam int DROP = swtm_pkg::DROP_HIGH;
  localparam int KEEP = swtm_pkg::KEEP_COUNT;
  localparam int SW   = swtm_pkg::SAMPLE_W;

  logic [SW-1:0] window [WIN];
  logic [SW-1:0] expected_means [$];
  logic [SW-1:0] want;

  // rank the window largest first, sum the kept ranks, floor-divide
  function automatic logic [SW-1:0] trimmed_mean_of_window();
    logic [SW-1:0] ranked [WIN];
    logic [SW-1:0] key;
    logic [31:0]   acc;
    int            k;
    int            last_rank;
    int            divisor;
    for (int i = 0; i < WIN; i++) ranked[i] = window[i];
    for (int i = 1; i < WIN; i++) begin
      key = ranked[i];
      k   = i;
      while (k > 0 && ranked[k-1] < key) begin
        ranked[k] = ranked[k-1];
        k--;
      end
      ranked[k] = key;
    end
    last_rank = (DROP + KEEP > WIN) ? WIN : DROP + KEEP;
    divisor   = (KEEP == 0) ? 1 : KEEP;
    acc = '0;
    for (int i = DROP; i < last_rank; i++) acc += ranked[i];
    return SW'(acc / divisor);
  endfunction

  initial begin
    mismatches    = 0;
    pending       = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) window[i] = '0;
      expected_means.delete();
    end else begin
      // a result leaving on this edge cannot come from a word entering on it
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          $display("%0t: filtered word with none expected: expected none, got %h",
                   $time, out_filtered);
        end else begin
          want = expected_means.pop_front();
          words_checked++;
          if (out_filtered !== want) begin
            mismatches++;
            $display("%0t: filtered mismatch: expected %h, got %h",
                     $time, want, out_filtered);
          end
        end
      end
      if (in_valid && in_ready) begin
        for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = in_sample;
        expected_means.push_back(trimmed_mean_of_window());
      end
    end
    pending = expected_means.size();
  end

endmodule

/* tb/sliding_window_trimmed_mean_unit_tb.sv */
// Testbench top for the sliding-window trimmed-mean unit: clock, reset,
// sample stimulus with random gaps, output back-pressure and the verdict.
// Depends on swtm_pkg, sliding_window_trimmed_mean_unit, trimmed_mean_checker.
`timescale 1ns / 1ps

module sliding_window_trimmed_mean_unit_tb;

  localparam int SW          = swtm_pkg::SAMPLE_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int BURSTS      = 30;
  localparam int BURST_LEN   = 32;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;

  typedef enum int {
    MIX_FULL,
    MIX_HIGH,
    MIX_LOW,
    MIX_FLAT,
    MIX_BITS,
    MIX_SPIKE
  } sample_mix_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [SW-1:0] in_sample;
  logic          out_valid;
  logic          out_ready;
  logic [SW-1:0] out_filtered;

  int unsigned   mismatches;
  int unsigned   pending;
  int unsigned   words_checked;
  int unsigned   samples_sent;
  int unsigned   words_taken;

  sliding_window_trimmed_mean_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

  trimmed_mean_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_filtered  (out_filtered),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // valid is only lowered when a gap follows, so back-to-back words keep it high
  task automatic send_sample(input logic [SW-1:0] value, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [SW-1:0] draw_sample(input sample_mix_t mix,
                                                input logic [SW-1:0] base);
    logic [SW-1:0] v;
    case (mix)
      MIX_FULL:  v = SW'($urandom);
      MIX_HIGH:  v = 16'hFF00 | SW'($urandom_range(0, 255));
      MIX_LOW:   v = SW'($urandom_range(0, 255));
      MIX_FLAT:  v = base;
      MIX_BITS:  v = ($urandom_range(0, 1) != 0) ? (16'h0001 << $urandom_range(0, 15))
                                                 : ~(16'h0001 << $urandom_range(0, 15));
      default: begin
        // outliers on a steady level: the trimming should hide them
        if ($urandom_range(0, 7) == 0) v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else v = base ^ SW'($urandom_range(0, 15));
      end
    endcase
    return v;
  endfunction

  function automatic int draw_gap(input bit no_gaps);
    return no_gaps ? 0 : $urandom_range(0, 14);
  endfunction

  // receiver: random stalls, stall-free stretches, one long hold-off
  initial begin : receiver
    int  stall;
    bit  no_stalls;
    out_ready <= 1'b0;
    words_taken = 0;
    no_stalls = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (words_taken % 50 == 0) no_stalls = ($urandom_range(0, 3) == 0);
      stall = no_stalls ? 0 : $urandom_range(0, 14);
      if (words_taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [SW-1:0] directed [25];
    logic [SW-1:0] base;
    sample_mix_t   mix;
    bit            no_gaps;
    samples_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    // start-up with reset zeros, both extremes, a run of ties, single bits
    directed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                 16'h0000, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
                 16'h1234, 16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE, 16'h5555,
                 16'hAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_sample(directed[i], draw_gap(1'b0));
    for (int b = 0; b < BURSTS; b++) begin
      mix     = sample_mix_t'($urandom_range(MIX_FULL, MIX_SPIKE));
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       base = 16'h0000;
        1:       base = 16'hFFFF;
        default: base = SW'($urandom);
      endcase
      for (int j = 0; j < BURST_LEN; j++) send_sample(draw_sample(mix, base), draw_gap(no_gaps));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d samples (extremes, ties, start-up zeros, outliers) and %0d",
             samples_sent, words_checked);
    $display("filtered words checked, with random gaps, stalls and one long output hold-off");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
